>>> design/pidq_pkg.sv
// ============================================================================
// pidq_pkg
// Shared types and constants of the packet impairment delay queue.
// ============================================================================
package pidq_pkg;

    localparam int unsigned SLOT_NUM_W  = 4;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned DIV_STEPS   = 32;

    localparam logic [31:0] LCG_MUL        = 32'd1664525;
    localparam logic [31:0] LCG_INC        = 32'd1013904223;
    localparam logic [31:0] LCG_SEED_RESET = 32'h12345678;
    localparam logic [16:0] LOSS_MODULUS   = 17'd10000;

    typedef logic [SLOT_NUM_W-1:0] slot_num_t;

    typedef enum logic [0:0] {
        FUNC_SEND = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ACT_FORWARDED = 3'd0,
        ACT_QUEUED    = 3'd1,
        ACT_DROPPED   = 3'd2,
        ACT_REJECTED  = 3'd3,
        ACT_FULL      = 3'd4,
        ACT_RELEASED  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        CFG_LATENCY = 2'd0,
        CFG_JITTER  = 2'd1,
        CFG_LOSS    = 2'd2,
        CFG_SEED    = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEND,
        S_LOSS_DRAW,
        S_LOSS_START,
        S_LOSS_WAIT,
        S_JIT_DRAW,
        S_JIT_START,
        S_JIT_WAIT,
        S_DELAY,
        S_FREE_SCAN,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_FLUSH,
        S_EMIT
    } state_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] now_ms;
        logic [7:0]  peer_id;
        logic [7:0]  channel;
        logic [15:0] packet_handle;
        logic [15:0] size;
        logic        reliable;
    } in_item_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  out_peer;
        logic [7:0]  out_channel;
        logic [15:0] out_handle;
        logic [15:0] out_size;
        logic        out_reliable;
        slot_num_t   slot_index;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [31:0] due;
        logic [7:0]  peer;
        logic [7:0]  channel;
        logic [15:0] handle;
        logic [15:0] length;
        logic        reliable;
    } slot_entry_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [16:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] rem;
    } mod_rsp_t;

endpackage

>>> design/pidq_if.sv
// ============================================================================
// pidq interfaces
// Valid/ready channels for input items, results and register writes.
// ============================================================================
interface pidq_in_if;
    logic               valid;
    logic               ready;
    pidq_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pidq_out_if;
    logic              valid;
    logic              ready;
    pidq_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pidq_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/pidq_mod_unit.sv
// ============================================================================
// pidq_mod_unit
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// ============================================================================
module pidq_mod_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  pidq_pkg::mod_req_t req,
    output pidq_pkg::mod_rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(pidq_pkg::DIV_STEPS + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [31:0]      quo_reg, quo_next;
    logic [16:0]      rem_reg, rem_next;
    logic [16:0]      div_reg, div_next;
    logic [17:0]      trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[31]};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            cnt_next = CNT_W'(pidq_pkg::DIV_STEPS);
            quo_next = req.dividend;
            rem_next = '0;
            div_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[30:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = 17'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[16:0];
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> design/packet_impairment_delay_queue.sv
// ============================================================================
// packet_impairment_delay_queue
// Network impairment emulator: loss, latency and jitter with a slot queue.
// ============================================================================
// One item at a time. In a send beat each random draw (loss, then jitter) is
// reduced by a shared 32-step remainder unit, and the free slot search walks
// the busy bits one slot per cycle. A tick beat reads each slot scanned from
// the slot memory and then compares its due time; each release after the
// first waits in a flush state for the output. Releases are capped at 16.
// No clearing pass after reset.
module packet_impairment_delay_queue #(
    parameter int unsigned QUEUE_SLOTS      = 16,
    parameter int unsigned MAX_PACKET_BYTES = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    pidq_cfg_if.sink          cfg,
    pidq_in_if.sink           pkt_in,
    pidq_out_if.source        pkt_out
);

    localparam int unsigned IDX_W  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int unsigned CNT_W  = $clog2(QUEUE_SLOTS + 1);
    localparam int unsigned RCNT_W = $clog2(pidq_pkg::MAX_RESULTS + 1);

    pidq_pkg::state_t      state_reg, state_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      idx;
    logic [RCNT_W-1:0]     rcnt_reg, rcnt_next;
    logic                  hold_reg, hold_next;
    logic [QUEUE_SLOTS-1:0] busy_reg, busy_next;
    logic [31:0]           lcg_reg, lcg_next;
    logic [15:0]           latency_reg, latency_next;
    logic [15:0]           jitter_reg, jitter_next;
    logic [13:0]           loss_reg, loss_next;
    logic [16:0]           delay_reg, delay_next;
    logic [31:0]           now_reg, now_next;
    pidq_pkg::result_t     res_reg, res_next;
    pidq_pkg::result_t     out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    pidq_pkg::slot_entry_t slot_mem [QUEUE_SLOTS];
    pidq_pkg::slot_entry_t rd_reg;
    pidq_pkg::slot_entry_t mem_wdata;
    logic                  mem_we;

    pidq_pkg::mod_req_t    mod_req;
    pidq_pkg::mod_rsp_t    mod_rsp;

    logic                  in_accept;
    logic                  out_free;
    logic                  scan_end;
    logic                  size_bad;
    logic                  slot_due;
    logic [31:0]           rel_time;
    logic [31:0]           lcg_step;
    logic [17:0]           jit_sum;

    pidq_mod_unit u_mod (
        .clk (clk),
        .rst_n (rst_n),
        .req (mod_req),
        .rsp (mod_rsp)
    );

    assign idx       = idx_reg[IDX_W-1:0];
    assign in_accept = pkt_in.valid && pkt_in.ready;
    assign out_free  = !out_valid_reg || pkt_out.ready;
    assign scan_end  = (idx_reg == CNT_W'(QUEUE_SLOTS));
    assign size_bad  = (res_reg.out_size == '0) ||
                       ({1'b0, res_reg.out_size} > 17'(MAX_PACKET_BYTES));
    assign rel_time  = now_reg - rd_reg.due;
    assign slot_due  = busy_reg[idx] && !rel_time[31];
    assign lcg_step  = 32'(lcg_reg * pidq_pkg::LCG_MUL) + pidq_pkg::LCG_INC;
    assign jit_sum   = 18'(latency_reg) + 18'(mod_rsp.rem);

    assign pkt_in.ready  = (state_reg == pidq_pkg::S_IDLE);
    assign cfg.ready     = 1'b1;
    assign pkt_out.valid = out_valid_reg;
    assign pkt_out.data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pidq_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (pkt_in.data.func == pidq_pkg::FUNC_TICK) ?
                                 pidq_pkg::S_TICK_RD : pidq_pkg::S_SEND;
                end
            end
            pidq_pkg::S_SEND:
            begin
                if (size_bad)
                begin
                    state_next = pidq_pkg::S_EMIT;
                end
                else if (!res_reg.out_reliable && loss_reg != '0)
                begin
                    state_next = pidq_pkg::S_LOSS_DRAW;
                end
                else
                begin
                    state_next = pidq_pkg::S_JIT_DRAW;
                end
            end
            pidq_pkg::S_LOSS_DRAW:  state_next = pidq_pkg::S_LOSS_START;
            pidq_pkg::S_LOSS_START: state_next = pidq_pkg::S_LOSS_WAIT;
            pidq_pkg::S_LOSS_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    state_next = (mod_rsp.rem < 17'(loss_reg)) ?
                                 pidq_pkg::S_EMIT : pidq_pkg::S_JIT_DRAW;
                end
            end
            pidq_pkg::S_JIT_DRAW:
            begin
                state_next = (jitter_reg == '0) ? pidq_pkg::S_DELAY : pidq_pkg::S_JIT_START;
            end
            pidq_pkg::S_JIT_START: state_next = pidq_pkg::S_JIT_WAIT;
            pidq_pkg::S_JIT_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    state_next = pidq_pkg::S_DELAY;
                end
            end
            pidq_pkg::S_DELAY:
            begin
                state_next = (delay_reg == '0) ? pidq_pkg::S_EMIT : pidq_pkg::S_FREE_SCAN;
            end
            pidq_pkg::S_FREE_SCAN:
            begin
                if (scan_end || !busy_reg[idx])
                begin
                    state_next = pidq_pkg::S_EMIT;
                end
            end
            pidq_pkg::S_TICK_RD:
            begin
                if (scan_end || rcnt_reg == RCNT_W'(pidq_pkg::MAX_RESULTS))
                begin
                    state_next = hold_reg ? pidq_pkg::S_EMIT : pidq_pkg::S_IDLE;
                end
                else
                begin
                    state_next = pidq_pkg::S_TICK_CHK;
                end
            end
            pidq_pkg::S_TICK_CHK:
            begin
                state_next = (slot_due && hold_reg) ? pidq_pkg::S_TICK_FLUSH :
                                                      pidq_pkg::S_TICK_RD;
            end
            pidq_pkg::S_TICK_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = pidq_pkg::S_TICK_CHK;
                end
            end
            pidq_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = pidq_pkg::S_IDLE;
                end
            end
            default: state_next = pidq_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        idx_next         = idx_reg;
        rcnt_next        = rcnt_reg;
        hold_next        = hold_reg;
        busy_next        = busy_reg;
        lcg_next         = lcg_reg;
        latency_next     = latency_reg;
        jitter_next      = jitter_reg;
        loss_next        = loss_reg;
        delay_next       = delay_reg;
        now_next         = now_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;
        mem_we           = 1'b0;
        mem_wdata.due      = now_reg + 32'(delay_reg);
        mem_wdata.peer     = res_reg.out_peer;
        mem_wdata.channel  = res_reg.out_channel;
        mem_wdata.handle   = res_reg.out_handle;
        mem_wdata.length   = res_reg.out_size;
        mem_wdata.reliable = res_reg.out_reliable;
        mod_req.start    = 1'b0;
        mod_req.dividend = lcg_reg;
        mod_req.divisor  = pidq_pkg::LOSS_MODULUS;

        if (out_valid_reg && pkt_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid && cfg.ready)
        begin
            unique case (pidq_pkg::cfg_reg_t'(cfg.index))
                pidq_pkg::CFG_LATENCY: latency_next = cfg.data[15:0];
                pidq_pkg::CFG_JITTER:  jitter_next  = cfg.data[15:0];
                pidq_pkg::CFG_LOSS:    loss_next    = cfg.data[13:0];
                pidq_pkg::CFG_SEED:    lcg_next     = cfg.data;
                default: ;
            endcase
        end

        unique case (state_reg)
            pidq_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    now_next              = pkt_in.data.now_ms;
                    res_next.action       = pidq_pkg::ACT_FORWARDED;
                    res_next.out_peer     = pkt_in.data.peer_id;
                    res_next.out_channel  = pkt_in.data.channel;
                    res_next.out_handle   = pkt_in.data.packet_handle;
                    res_next.out_size     = pkt_in.data.size;
                    res_next.out_reliable = pkt_in.data.reliable;
                    res_next.slot_index   = '0;
                    res_next.last         = 1'b1;
                    idx_next              = '0;
                    rcnt_next             = '0;
                    hold_next             = 1'b0;
                end
            end
            pidq_pkg::S_SEND:
            begin
                if (size_bad)
                begin
                    res_next.action = pidq_pkg::ACT_REJECTED;
                end
            end
            pidq_pkg::S_LOSS_DRAW:
            begin
                lcg_next = lcg_step;
            end
            pidq_pkg::S_LOSS_START:
            begin
                mod_req.start = 1'b1;
            end
            pidq_pkg::S_LOSS_WAIT:
            begin
                if (mod_rsp.done && mod_rsp.rem < 17'(loss_reg))
                begin
                    res_next.action = pidq_pkg::ACT_DROPPED;
                end
            end
            pidq_pkg::S_JIT_DRAW:
            begin
                if (jitter_reg == '0)
                begin
                    delay_next = 17'(latency_reg);
                end
                else
                begin
                    lcg_next = lcg_step;
                end
            end
            pidq_pkg::S_JIT_START:
            begin
                mod_req.start   = 1'b1;
                mod_req.divisor = {jitter_reg, 1'b1};
            end
            pidq_pkg::S_JIT_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    delay_next = (jit_sum > 18'(jitter_reg)) ?
                                 17'(jit_sum - 18'(jitter_reg)) : '0;
                end
            end
            pidq_pkg::S_DELAY:
            begin
                idx_next = '0;
            end
            pidq_pkg::S_FREE_SCAN:
            begin
                if (scan_end)
                begin
                    res_next.action = pidq_pkg::ACT_FULL;
                end
                else if (!busy_reg[idx])
                begin
                    mem_we              = 1'b1;
                    busy_next[idx]      = 1'b1;
                    res_next.action     = pidq_pkg::ACT_QUEUED;
                    res_next.slot_index = pidq_pkg::SLOT_NUM_W'(idx);
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            pidq_pkg::S_TICK_RD: ;
            pidq_pkg::S_TICK_CHK:
            begin
                if (slot_due && !hold_reg)
                begin
                    res_next.action       = pidq_pkg::ACT_RELEASED;
                    res_next.out_peer     = rd_reg.peer;
                    res_next.out_channel  = rd_reg.channel;
                    res_next.out_handle   = rd_reg.handle;
                    res_next.out_size     = rd_reg.length;
                    res_next.out_reliable = rd_reg.reliable;
                    res_next.slot_index   = pidq_pkg::SLOT_NUM_W'(idx);
                    busy_next[idx]        = 1'b0;
                    rcnt_next             = rcnt_reg + 1'b1;
                    hold_next             = 1'b1;
                    idx_next              = idx_reg + 1'b1;
                end
                else if (!slot_due)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            pidq_pkg::S_TICK_FLUSH:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_next.last  = 1'b0;
                    out_valid_next = 1'b1;
                    hold_next      = 1'b0;
                end
            end
            pidq_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_next.last  = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pidq_pkg::S_IDLE;
            idx_reg       <= '0;
            rcnt_reg      <= '0;
            hold_reg      <= 1'b0;
            busy_reg      <= '0;
            lcg_reg       <= pidq_pkg::LCG_SEED_RESET;
            latency_reg   <= '0;
            jitter_reg    <= '0;
            loss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rcnt_reg      <= rcnt_next;
            hold_reg      <= hold_next;
            busy_reg      <= busy_next;
            lcg_reg       <= lcg_next;
            latency_reg   <= latency_next;
            jitter_reg    <= jitter_next;
            loss_reg      <= loss_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delay_reg <= delay_next;
        now_reg   <= now_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[idx] <= mem_wdata;
        end
        rd_reg <= slot_mem[idx];
    end

endmodule

>>> design/pidq_checker.sv
// ============================================================================
// pidq_checker
// Port-level checks of the packet impairment delay queue, bound to the top.
// ============================================================================
module pidq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input pidq_pkg::action_t   out_action,
    input pidq_pkg::slot_num_t out_slot,
    input logic                out_last
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_action) &&
        $stable(out_slot) && $stable(out_last))
        else $error("stalled result beat changed");

    // one item in flight
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // send results are single beats
    a_send_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_action != pidq_pkg::ACT_RELEASED |-> out_last)
        else $error("send result without last");

    // slot number only on queued or released
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_action != pidq_pkg::ACT_QUEUED &&
        out_action != pidq_pkg::ACT_RELEASED |-> out_slot == '0)
        else $error("slot number on a result without a slot");

endmodule

bind packet_impairment_delay_queue pidq_checker u_pidq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pkt_in.valid),
    .in_ready   (pkt_in.ready),
    .out_valid  (pkt_out.valid),
    .out_ready  (pkt_out.ready),
    .out_action (pkt_out.data.action),
    .out_slot   (pkt_out.data.slot_index),
    .out_last   (pkt_out.data.last)
);

>>> test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking run for the packet impairment delay queue. A driver and a
// monitor clocked from one edge move send and tick beats through the block
// with random gaps and stalls. An in-bench emulation of loss, latency, jitter
// and slot release predicts every result beat, and each result is compared
// field by field with the oldest prediction. The run covers directed corner
// items and then several register settings with random traffic.
// ============================================================================
module testbench;

    localparam int unsigned QUEUE_SLOTS      = 16;
    localparam int unsigned MAX_PACKET_BYTES = 1024;
    localparam int unsigned PHASE_ITEMS      = 64;
    localparam int unsigned SETTLE_CYCLES    = 200;

    logic clk = 1'b0;
    logic rst_n;

    pidq_cfg_if cfg_bus ();
    pidq_in_if  in_bus ();
    pidq_out_if out_bus ();

    packet_impairment_delay_queue #(
        .QUEUE_SLOTS      (QUEUE_SLOTS),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .pkt_in  (in_bus),
        .pkt_out (out_bus)
    );

    always #6 clk = ~clk;

    // emulated block state
    logic [31:0]           latency_set = '0;
    logic [31:0]           jitter_set  = '0;
    logic [31:0]           loss_set    = '0;
    logic [31:0]           lcg_value   = pidq_pkg::LCG_SEED_RESET;
    logic                  held_busy [QUEUE_SLOTS];
    pidq_pkg::slot_entry_t held_slot [QUEUE_SLOTS];

    pidq_pkg::in_item_t    pending_items [$];
    pidq_pkg::result_t     outcome_q [$];
    logic [31:0]           clock_ms;
    bit                    steady = 1'b0;
    int unsigned           fail_count = 0;

    function automatic bit hold_off();
        return !steady && ($urandom_range(99) < 16);
    endfunction

    function automatic logic [31:0] next_rand();
        lcg_value = lcg_value * pidq_pkg::LCG_MUL + pidq_pkg::LCG_INC;
        return lcg_value;
    endfunction

    function automatic void apply_setting(pidq_pkg::cfg_reg_t idx, logic [31:0] val);
        case (idx)
            pidq_pkg::CFG_LATENCY: latency_set = {16'd0, val[15:0]};
            pidq_pkg::CFG_JITTER:  jitter_set  = {16'd0, val[15:0]};
            pidq_pkg::CFG_LOSS:    loss_set    = {18'd0, val[13:0]};
            pidq_pkg::CFG_SEED:    lcg_value   = val;
            default: ;
        endcase
    endfunction

    function automatic void emulate_impairment(pidq_pkg::in_item_t it);
        pidq_pkg::result_t r;
        pidq_pkg::result_t prev;
        bit                have_prev;
        bit                lost;
        logic [31:0]       age;
        logic [31:0]       delay;
        logic [31:0]       span;
        logic [31:0]       sum;
        int                free_idx;
        r = '0;
        have_prev = 1'b0;
        if (it.func == pidq_pkg::FUNC_TICK)
        begin
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                age = it.now_ms - held_slot[i].due;
                if (held_busy[i] && !age[31])
                begin
                    if (have_prev)
                        outcome_q.push_back(prev);
                    prev.action       = pidq_pkg::ACT_RELEASED;
                    prev.out_peer     = held_slot[i].peer;
                    prev.out_channel  = held_slot[i].channel;
                    prev.out_handle   = held_slot[i].handle;
                    prev.out_size     = held_slot[i].length;
                    prev.out_reliable = held_slot[i].reliable;
                    prev.slot_index   = pidq_pkg::slot_num_t'(i);
                    prev.last         = 1'b0;
                    have_prev = 1'b1;
                    held_busy[i] = 1'b0;
                end
            end
            if (have_prev)
            begin
                prev.last = 1'b1;
                outcome_q.push_back(prev);
            end
            return;
        end
        r.out_peer     = it.peer_id;
        r.out_channel  = it.channel;
        r.out_handle   = it.packet_handle;
        r.out_size     = it.size;
        r.out_reliable = it.reliable;
        r.slot_index   = '0;
        r.last         = 1'b1;
        lost = 1'b0;
        if (it.size == 16'd0 || it.size > MAX_PACKET_BYTES)
        begin
            r.action = pidq_pkg::ACT_REJECTED;
        end
        else
        begin
            if (!it.reliable && loss_set != 0)
                lost = (next_rand() % pidq_pkg::LOSS_MODULUS) < loss_set;
            if (lost)
            begin
                r.action = pidq_pkg::ACT_DROPPED;
            end
            else
            begin
                delay = latency_set;
                if (jitter_set != 0)
                begin
                    span  = jitter_set * 2 + 1;
                    sum   = latency_set + next_rand() % span;
                    delay = (sum > jitter_set) ? sum - jitter_set : 32'd0;
                end
                if (delay == 0)
                begin
                    r.action = pidq_pkg::ACT_FORWARDED;
                end
                else
                begin
                    free_idx = -1;
                    for (int i = QUEUE_SLOTS - 1; i >= 0; i--)
                        if (!held_busy[i])
                            free_idx = i;
                    if (free_idx < 0)
                    begin
                        r.action = pidq_pkg::ACT_FULL;
                    end
                    else
                    begin
                        held_busy[free_idx]          = 1'b1;
                        held_slot[free_idx].due      = it.now_ms + delay;
                        held_slot[free_idx].peer     = it.peer_id;
                        held_slot[free_idx].channel  = it.channel;
                        held_slot[free_idx].handle   = it.packet_handle;
                        held_slot[free_idx].length   = it.size;
                        held_slot[free_idx].reliable = it.reliable;
                        r.action     = pidq_pkg::ACT_QUEUED;
                        r.slot_index = pidq_pkg::slot_num_t'(free_idx);
                    end
                end
            end
        end
        outcome_q.push_back(r);
    endfunction

    function automatic void check_outcome(pidq_pkg::result_t got);
        pidq_pkg::result_t want;
        if (outcome_q.size() == 0)
        begin
            if (fail_count < 10)
                $display("unexpected result beat: act=%0d peer=%h ch=%h handle=%h size=%h",
                         got.action, got.out_peer, got.out_channel, got.out_handle,
                         got.out_size);
            fail_count++;
            return;
        end
        want = outcome_q.pop_front();
        if (got.action !== want.action || got.out_peer !== want.out_peer ||
            got.out_channel !== want.out_channel || got.out_handle !== want.out_handle ||
            got.out_size !== want.out_size || got.out_reliable !== want.out_reliable ||
            got.slot_index !== want.slot_index || got.last !== want.last)
        begin
            if (fail_count < 10)
            begin
                $display("mismatch expected: act=%0d peer=%h ch=%h handle=%h size=%h",
                         want.action, want.out_peer, want.out_channel, want.out_handle,
                         want.out_size);
                $display("                   rel=%b slot=%0d last=%b",
                         want.out_reliable, want.slot_index, want.last);
                $display("         actual:   act=%0d peer=%h ch=%h handle=%h size=%h",
                         got.action, got.out_peer, got.out_channel, got.out_handle,
                         got.out_size);
                $display("                   rel=%b slot=%0d last=%b",
                         got.out_reliable, got.slot_index, got.last);
            end
            fail_count++;
        end
    endfunction

    function automatic pidq_pkg::in_item_t make_item(pidq_pkg::func_t f, logic [31:0] now,
                                                     logic [7:0] peer, logic [7:0] ch,
                                                     logic [15:0] handle,
                                                     logic [15:0] sz, logic rel);
        pidq_pkg::in_item_t it;
        it.func          = f;
        it.now_ms        = now;
        it.peer_id       = peer;
        it.channel       = ch;
        it.packet_handle = handle;
        it.size          = sz;
        it.reliable      = rel;
        return it;
    endfunction

    // input beat driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bus.valid <= 1'b0;
        end
        else
        begin
            if (in_bus.valid && in_bus.ready)
                emulate_impairment(in_bus.data);
            if (!in_bus.valid || in_bus.ready)
            begin
                if (pending_items.size() != 0 && !hold_off())
                begin
                    in_bus.data  <= pending_items.pop_front();
                    in_bus.valid <= 1'b1;
                end
                else
                begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result beat monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
        end
        else
        begin
            if (out_bus.valid && out_bus.ready)
                check_outcome(out_bus.data);
            out_bus.ready <= !hold_off();
        end
    end

    task automatic write_reg(pidq_pkg::cfg_reg_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        apply_setting(idx, val);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || in_bus.valid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_all(logic [15:0] lat, logic [15:0] jit, logic [13:0] loss,
                             logic [31:0] seed);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(pidq_pkg::CFG_LATENCY, {junk[31:16], lat});
        junk = $urandom;
        write_reg(pidq_pkg::CFG_JITTER, {junk[31:16], jit});
        junk = $urandom;
        write_reg(pidq_pkg::CFG_LOSS, {junk[31:14], loss});
        write_reg(pidq_pkg::CFG_SEED, seed);
    endtask

    task automatic run_phase(logic [15:0] lat, logic [15:0] jit, logic [13:0] loss,
                             logic [31:0] seed, bit calm);
        pidq_pkg::in_item_t it;
        int unsigned        roll;
        logic [15:0]        sz;
        write_all(lat, jit, loss, seed);
        steady = calm;
        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            clock_ms = clock_ms + $urandom_range(6);
            roll = $urandom_range(99);
            if (roll < 5)
                sz = 16'd0;
            else if (roll < 10)
                sz = 16'($urandom_range(65535, MAX_PACKET_BYTES + 1));
            else
                sz = 16'($urandom_range(MAX_PACKET_BYTES, 1));
            it = make_item(($urandom_range(99) < 30) ? pidq_pkg::FUNC_TICK :
                                                       pidq_pkg::FUNC_SEND,
                           clock_ms, 8'($urandom), 8'($urandom), 16'($urandom), sz,
                           1'($urandom));
            if ($urandom_range(99) < 10)
                it.now_ms = $urandom;
            pending_items.push_back(it);
        end
        // far-future tick releases every slot due by then before the next setting
        clock_ms = clock_ms + 32'h0004_0000;
        pending_items.push_back(make_item(pidq_pkg::FUNC_TICK, clock_ms, '0, '0, '0, '0,
                                          1'b0));
        drain();
        steady = 1'b0;
    endtask

    initial
    begin
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [31:0] t0;
        rst_n          = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.data    = '0;
        out_bus.ready  = 1'b0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.index  = pidq_pkg::CFG_LATENCY;
        cfg_bus.data   = '0;
        for (int i = 0; i < QUEUE_SLOTS; i++)
            held_busy[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // reset settings: field extremes and size limits
        pending_items.push_back(make_item(pidq_pkg::FUNC_SEND, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
                                          16'hFFFF, 16'(MAX_PACKET_BYTES), 1'b1));
        pending_items.push_back(make_item(pidq_pkg::FUNC_SEND, '0, '0, '0, '0, 16'd1,
                                          1'b0));
        pending_items.push_back(make_item(pidq_pkg::FUNC_SEND, 32'd7, 8'h5A, 8'hA5,
                                          16'h1234, 16'd0, 1'b0));
        pending_items.push_back(make_item(pidq_pkg::FUNC_SEND, 32'd8, 8'h01, 8'h02,
                                          16'h0003, 16'(MAX_PACKET_BYTES + 1), 1'b1));
        pending_items.push_back(make_item(pidq_pkg::FUNC_SEND, 32'd9, 8'h80, 8'h40,
                                          16'h8000, 16'hFFFF, 1'b0));
        pending_items.push_back(make_item(pidq_pkg::FUNC_TICK, 32'd10, '0, '0, '0, '0,
                                          1'b0));
        drain();

        // full loss, fill every slot across the time wrap, overflow, release
        write_all(16'd5, 16'd0, 14'h3FFF, 32'h8765_4321);
        t0 = 32'hFFFF_FFFD;
        pending_items.push_back(make_item(pidq_pkg::FUNC_SEND, t0, 8'h11, 8'h22, 16'h0BAD,
                                          16'd100, 1'b0));
        for (int i = 0; i < QUEUE_SLOTS; i++)
            pending_items.push_back(make_item(pidq_pkg::FUNC_SEND, t0, 8'(i), 8'(255 - i),
                                              16'(i), 16'(i + 1), 1'b1));
        pending_items.push_back(make_item(pidq_pkg::FUNC_SEND, t0, 8'h77, 8'h66, 16'hFFFF,
                                          16'd64, 1'b1));
        pending_items.push_back(make_item(pidq_pkg::FUNC_TICK, t0 + 32'd4, '0, '0, '0, '0,
                                          1'b0));
        pending_items.push_back(make_item(pidq_pkg::FUNC_TICK, t0 + 32'd5, '0, '0, '0, '0,
                                          1'b0));
        drain();

        clock_ms = 32'hFFFF_FF80;
        run_phase(16'd10, 16'd8, 14'd2500, $urandom, 1'b0);
        run_phase(16'd0, 16'd5, 14'd0, 32'h0000_0000, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 14'd10000, 32'hFFFF_FFFF, 1'b0);
        run_phase(16'($urandom_range(40)), 16'($urandom_range(30)),
                  14'($urandom_range(10000)), $urandom, 1'b0);
        run_phase(16'd3, 16'd0, 14'd5000, $urandom, 1'b0);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
design/pidq_pkg.sv
design/pidq_if.sv
design/pidq_mod_unit.sv
design/packet_impairment_delay_queue.sv
design/pidq_checker.sv
test/testbench.sv
